// File: rtl/ped_pkg.sv
// shared types and constants for the pairwise euclidean distance block
package ped_pkg;

    localparam int DEF_MAX_CENTERS   = 64;
    localparam int DEF_COORD_BITS    = 16;
    localparam int DEF_MAX_DIMENSION = 3;

    localparam int FIELD_W  = 16;
    localparam int SLOT_W   = 6;
    localparam int NUM_W    = 6;
    localparam int DIST_W   = 17;
    localparam int DIM_W    = 2;
    localparam int CENT_W   = 7;
    localparam int CFG_IX_W = 1;
    localparam int CFG_D_W  = 7;

    localparam logic [DIST_W-1:0] DIST_MAX    = 17'h1FFFF;
    localparam logic [DIM_W-1:0]  DIM_RESET   = 2'd2;
    localparam logic [CENT_W-1:0] CENT_RESET  = 7'd64;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [CFG_IX_W-1:0] REG_DIMENSION = 1'b0;
    localparam logic [CFG_IX_W-1:0] REG_CENTERS   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_ROOT_GO,
        ST_ROOT_WAIT
    } t_state;

endpackage

// File: rtl/ped_ram.sv
// generic single write port ram with registered read
module ped_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ped_sqrt.sv
// iterative floor square root, two radicand bits per cycle
module ped_sqrt #(
    parameter int RAD_W = 34,
    localparam int H = RAD_W / 2,
    localparam int CW = $clog2(H + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RAD_W-1:0] i_radicand,
    output logic             o_done,
    output logic [H-1:0]     o_root
);

    logic [RAD_W-1:0] r_rad, n_rad;
    logic [H:0]       r_rem, n_rem;
    logic [H-1:0]     r_root, n_root;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [H+2:0]     rem_sh;
    logic [H+2:0]     trial;
    logic [H+2:0]     diff;
    logic             ge;

    always_comb begin
        rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        diff   = rem_sh - trial;
        ge     = (rem_sh >= trial);

        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;

        if (i_start) begin
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = CW'(H);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad  = {r_rad[RAD_W-3:0], 2'b00};
            n_rem  = ge ? diff[H:0] : rem_sh[H:0];
            n_root = {r_root[H-2:0], ge};
            n_cnt  = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: rtl/pairwise_euclidean_distance.sv
// top level: center table, square-accumulate sequencer and result register
// a load never raises busy; a query holds busy until its last result
// per center, the time is set by the one shared multiplier and the iterative square root;
// results are strobed one per center
// the receiver cannot stall; results are single-cycle strobes
// reset restores dimension 2 and 64 centers in use; the center table is undefined until written
module pairwise_euclidean_distance #(
    parameter int MAX_CENTERS   = ped_pkg::DEF_MAX_CENTERS,
    parameter int COORD_BITS    = ped_pkg::DEF_COORD_BITS,
    parameter int MAX_DIMENSION = ped_pkg::DEF_MAX_DIMENSION
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic [ped_pkg::SLOT_W-1:0]    i_slot,
    input  logic signed [ped_pkg::FIELD_W-1:0] i_coord_x,
    input  logic signed [ped_pkg::FIELD_W-1:0] i_coord_y,
    input  logic signed [ped_pkg::FIELD_W-1:0] i_coord_z,
    input  logic                          i_cfg_we,
    input  logic [ped_pkg::CFG_IX_W-1:0]  i_cfg_index,
    input  logic [ped_pkg::CFG_D_W-1:0]   i_cfg_data,
    output logic                          o_strobe,
    output logic [ped_pkg::NUM_W-1:0]     o_center_number,
    output logic [ped_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_last
);

    localparam int C      = COORD_BITS;
    localparam int AW     = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int TW     = MAX_DIMENSION * C;
    localparam int SQ_W   = 2 * C + 1;
    localparam int SUM_W  = 2 * C + 2;
    localparam int SAT_W  = (SUM_W > 64) ? 64 : SUM_W;
    localparam int RAD_W  = SAT_W + (SAT_W % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int FW     = ped_pkg::FIELD_W;
    localparam int DW     = ped_pkg::DIST_W;
    localparam int KW     = ped_pkg::DIM_W;
    localparam int NW     = ped_pkg::CENT_W;

    ped_pkg::t_state r_state, n_state;

    logic [KW-1:0]   r_dimension, n_dimension;
    logic [NW-1:0]   r_centers, n_centers;
    logic [C-1:0]    r_site [MAX_DIMENSION];
    logic [C-1:0]    n_site [MAX_DIMENSION];
    logic [AW-1:0]   r_idx, n_idx;
    logic [KW-1:0]   r_k, n_k;
    logic [SQ_W-1:0] r_sq, n_sq;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic            r_strobe, n_strobe;
    logic [ped_pkg::NUM_W-1:0] r_num, n_num;
    logic [DW-1:0]   r_dist, n_dist;
    logic            r_last, n_last;

    logic [C-1:0]    coord_in [MAX_DIMENSION];
    logic [FW-1:0]   field_in [3];
    logic [C+FW-1:0] field_ext [MAX_DIMENSION];
    logic [TW-1:0]   wdata;
    logic [TW-1:0]   rdata;
    logic            accept;
    logic            ram_we;
    logic [KW-1:0]   eff_dim;
    logic [NW-1:0]   eff_count;
    logic            at_last;
    logic [C-1:0]    sel_site;
    logic [C-1:0]    sel_ctr;
    logic [C:0]      diff;
    logic [C:0]      mag;
    logic [2*C+1:0]  prod;
    logic [SUM_W+63:0] sum_wide;
    logic            sum_sat;
    logic [RAD_W-1:0] radicand;
    logic            root_start;
    logic            root_done;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W+DW-1:0] root_wide;
    logic            root_sat;

    assign field_in[0] = i_coord_x;
    assign field_in[1] = i_coord_y;
    assign field_in[2] = i_coord_z;

    always_comb begin
        for (int j = 0; j < MAX_DIMENSION; j++) begin
            field_ext[j] = {{C{1'b0}}, field_in[j]};
            coord_in[j]  = field_ext[j][C-1:0];
            wdata[j*C +: C] = coord_in[j];
        end
    end

    assign accept = start && !busy;
    assign ram_we = accept && (i_action == ped_pkg::ACT_LOAD)
                    && ({1'b0, i_slot} < (ped_pkg::SLOT_W + 1)'(MAX_CENTERS));

    ped_ram #(
        .WIDTH(TW),
        .DEPTH(MAX_CENTERS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(i_slot[AW-1:0]),
        .i_wdata(wdata),
        .i_raddr(r_idx),
        .o_rdata(rdata)
    );

    always_comb begin
        if (r_dimension == '0) begin
            eff_dim = KW'(1);
        end else if (r_dimension > KW'(MAX_DIMENSION)) begin
            eff_dim = KW'(MAX_DIMENSION);
        end else begin
            eff_dim = r_dimension;
        end
        if (r_centers > NW'(MAX_CENTERS)) begin
            eff_count = NW'(MAX_CENTERS);
        end else begin
            eff_count = r_centers;
        end
    end

    assign at_last = (NW'(r_idx) + NW'(1)) == eff_count;

    // shared square unit operand select
    always_comb begin
        sel_site = r_site[0];
        sel_ctr  = rdata[C-1:0];
        for (int j = 0; j < MAX_DIMENSION; j++) begin
            if (r_k == KW'(j)) begin
                sel_site = r_site[j];
                sel_ctr  = rdata[j*C +: C];
            end
        end
        diff = {sel_site[C-1], sel_site} - {sel_ctr[C-1], sel_ctr};
        mag  = diff[C] ? (~diff + (C+1)'(1)) : diff;
        prod = {{(C+1){1'b0}}, mag} * {{(C+1){1'b0}}, mag};
    end

    always_comb begin
        sum_wide  = {64'd0, r_sum};
        sum_sat   = (sum_wide[SUM_W+63:SAT_W] != '0);
        radicand  = sum_sat ? RAD_W'({SAT_W{1'b1}}) : RAD_W'(sum_wide[SAT_W-1:0]);
        root_wide = {{DW{1'b0}}, root};
        root_sat  = (root_wide[ROOT_W+DW-1:DW] != '0);
    end

    assign root_start = (r_state == ped_pkg::ST_ROOT_GO);

    ped_sqrt #(
        .RAD_W(RAD_W)
    ) u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (root_start),
        .i_radicand(radicand),
        .o_done    (root_done),
        .o_root    (root)
    );

    always_comb begin
        n_state     = r_state;
        n_dimension = r_dimension;
        n_centers   = r_centers;
        n_site      = r_site;
        n_idx       = r_idx;
        n_k         = r_k;
        n_sq        = r_sq;
        n_sum       = r_sum;
        n_strobe    = 1'b0;
        n_num       = r_num;
        n_dist      = r_dist;
        n_last      = r_last;

        if (i_cfg_we) begin
            case (i_cfg_index)
                ped_pkg::REG_DIMENSION: n_dimension = i_cfg_data[KW-1:0];
                ped_pkg::REG_CENTERS:   n_centers   = i_cfg_data[NW-1:0];
                default: ;
            endcase
        end

        case (r_state)
            ped_pkg::ST_IDLE: begin
                if (accept && (i_action == ped_pkg::ACT_QUERY)) begin
                    n_site = coord_in;
                    n_idx  = '0;
                    if (eff_count != '0) begin
                        n_state = ped_pkg::ST_READ;
                    end
                end
            end
            ped_pkg::ST_READ: begin
                n_k     = '0;
                n_sum   = '0;
                n_state = ped_pkg::ST_MUL;
            end
            ped_pkg::ST_MUL: begin
                n_sq    = prod[SQ_W-1:0];
                n_state = ped_pkg::ST_ACC;
            end
            ped_pkg::ST_ACC: begin
                n_sum = r_sum + SUM_W'(r_sq);
                n_k   = r_k + KW'(1);
                if (r_k + KW'(1) == eff_dim) begin
                    n_state = ped_pkg::ST_ROOT_GO;
                end else begin
                    n_state = ped_pkg::ST_MUL;
                end
            end
            ped_pkg::ST_ROOT_GO: begin
                n_state = ped_pkg::ST_ROOT_WAIT;
            end
            ped_pkg::ST_ROOT_WAIT: begin
                if (root_done) begin
                    n_strobe = 1'b1;
                    n_num    = ped_pkg::NUM_W'(r_idx);
                    n_dist   = root_sat ? ped_pkg::DIST_MAX : root_wide[DW-1:0];
                    n_last   = at_last;
                    if (at_last) begin
                        n_state = ped_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = ped_pkg::ST_READ;
                    end
                end
            end
            default: n_state = ped_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ped_pkg::ST_IDLE;
            r_dimension <= ped_pkg::DIM_RESET;
            r_centers   <= ped_pkg::CENT_RESET;
            r_idx       <= '0;
            r_k         <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dimension <= n_dimension;
            r_centers   <= n_centers;
            r_idx       <= n_idx;
            r_k         <= n_k;
            r_strobe    <= n_strobe;
        end
        r_site <= n_site;
        r_sq   <= n_sq;
        r_sum  <= n_sum;
        r_num  <= n_num;
        r_dist <= n_dist;
        r_last <= n_last;
    end

    assign busy            = (r_state != ped_pkg::ST_IDLE);
    assign o_strobe        = r_strobe;
    assign o_center_number = r_num;
    assign o_distance      = r_dist;
    assign o_last          = r_last;

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("block went idle before the last result");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("block still busy after the last result");

    a_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results strobed in adjacent cycles");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> ($past(start) && ($past(i_action) == ped_pkg::ACT_QUERY)))
        else $error("busy raised without a query transaction");

endmodule

// File: verif/tb_top.sv
// self-checking testbench for the pairwise euclidean distance block: directed table, then random phases
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ped_pkg::*;

    localparam int N_CENTERS     = DEF_MAX_CENTERS;
    localparam int N_DIMS        = DEF_MAX_DIMENSION;
    localparam int RANDOM_ITEMS  = 390;
    localparam int MAX_GAP       = 12;
    localparam int SETTLE_CYCLES = 60;
    localparam int IDLE_LIMIT    = 4000;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [CFG_IX_W-1:0]       reg_ix;
        logic [CFG_D_W-1:0]        reg_data;
        logic                      action;
        logic [SLOT_W-1:0]         slot;
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
        bit                        typed;
        int unsigned               typed_dist;
    } t_dir_row;

    typedef struct {
        logic [NUM_W-1:0]  center_number;
        logic [DIST_W-1:0] distance;
        logic              last;
    } t_dist_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_action = ACT_LOAD;
    logic [SLOT_W-1:0]         i_slot = '0;
    logic signed [FIELD_W-1:0] i_coord_x = '0;
    logic signed [FIELD_W-1:0] i_coord_y = '0;
    logic signed [FIELD_W-1:0] i_coord_z = '0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IX_W-1:0]       i_cfg_index = '0;
    logic [CFG_D_W-1:0]        i_cfg_data = '0;
    logic                      o_strobe;
    logic [NUM_W-1:0]          o_center_number;
    logic [DIST_W-1:0]         o_distance;
    logic                      o_last;

    logic signed [FIELD_W-1:0] center_tab [N_CENTERS][N_DIMS];
    logic [DIM_W-1:0]          cfg_dim;
    logic [CENT_W-1:0]         cfg_centers;
    t_dist_result              dist_fifo [$];
    t_dir_row                  dir_rows [$];
    int                        mismatches = 0;
    int                        idle_cycles = 0;
    int                        burst_left = 0;

    pairwise_euclidean_distance u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_slot          (i_slot),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_center_number (o_center_number),
        .o_distance      (o_distance),
        .o_last          (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int active_centers();
        return (cfg_centers > N_CENTERS) ? N_CENTERS : int'(cfg_centers);
    endfunction

    function automatic int active_dims();
        if (cfg_dim == 0)
            return 1;
        return (cfg_dim > N_DIMS) ? N_DIMS : int'(cfg_dim);
    endfunction

    function automatic logic [DIST_W-1:0] floor_distance(
        input logic signed [FIELD_W-1:0] sx,
        input logic signed [FIELD_W-1:0] sy,
        input logic signed [FIELD_W-1:0] sz,
        input int                        c
    );
        logic signed [FIELD_W-1:0] site [N_DIMS];
        longint                    diff;
        longint unsigned           sum;
        longint unsigned           root;
        longint unsigned           trial;
        site[0] = sx;
        site[1] = sy;
        site[2] = sz;
        sum = 0;
        for (int k = 0; k < active_dims(); k++) begin
            diff = longint'(site[k]) - longint'(center_tab[c][k]);
            if (diff < 0)
                diff = -diff;
            sum += longint'(diff * diff);
        end
        // digit-by-digit floor root, msb first
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sum)
                root = trial;
        end
        if (root > DIST_MAX)
            return DIST_MAX;
        return root[DIST_W-1:0];
    endfunction

    function automatic t_dir_row cfg_row(input logic [CFG_IX_W-1:0] ix, input int data);
        return t_dir_row'{ROW_CFG, ix, CFG_D_W'(data), ACT_LOAD, '0, '0, '0, '0, 1'b0, 0};
    endfunction

    function automatic t_dir_row item_row(
        input logic act, input int sl, input int x, input int y, input int z,
        input bit typed, input int unsigned tdist
    );
        return t_dir_row'{ROW_ITEM, REG_DIMENSION, '0, act, SLOT_W'(sl), FIELD_W'(x),
                          FIELD_W'(y), FIELD_W'(z), typed, tdist};
    endfunction

    function automatic logic signed [FIELD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return FIELD_W'(int'($urandom_range(0, 15)) - 8);
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    task automatic record_transaction(
        input logic act, input logic [SLOT_W-1:0] sl,
        input logic signed [FIELD_W-1:0] cx, cy, cz,
        input bit typed, input int unsigned tdist
    );
        t_dist_result r;
        int           cnt;
        cnt = active_centers();
        if (act == ACT_LOAD) begin
            center_tab[sl][0] = cx;
            center_tab[sl][1] = cy;
            center_tab[sl][2] = cz;
        end else begin
            for (int i = 0; i < cnt; i++) begin
                r.center_number = NUM_W'(i);
                r.distance      = typed ? DIST_W'(tdist) : floor_distance(cx, cy, cz, i);
                r.last          = (i == cnt - 1);
                dist_fifo.push_back(r);
            end
        end
    endtask

    task automatic send_item(
        input logic act, input logic [SLOT_W-1:0] sl,
        input logic signed [FIELD_W-1:0] cx, cy, cz,
        input bit typed, input int unsigned tdist
    );
        int gap;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 24) == 0)
                burst_left = $urandom_range(10, 40);
        end
        // occasionally hold off until the block has drained
        if ($urandom_range(0, 39) == 0 && dist_fifo.size() != 0) begin
            start = 1'b0;
            while (dist_fifo.size() != 0)
                @(negedge i_clk);
        end
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start     = 1'b1;
        i_action  = act;
        i_slot    = sl;
        i_coord_x = cx;
        i_coord_y = cy;
        i_coord_z = cz;
        do @(posedge i_clk); while (busy);
        record_transaction(act, sl, cx, cy, cz, typed, tdist);
    endtask

    task automatic write_reg(input logic [CFG_IX_W-1:0] ix, input logic [CFG_D_W-1:0] data);
        @(negedge i_clk);
        start = 1'b0;
        while (dist_fifo.size() != 0 || busy)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = ix;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (ix == REG_DIMENSION)
            cfg_dim = data[DIM_W-1:0];
        else
            cfg_centers = data[CENT_W-1:0];
    endtask

    always @(posedge i_clk) begin
        t_dist_result want;
        if (i_rst_n && o_strobe) begin
            if (dist_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: center %0d distance %0d last %0b",
                             o_center_number, o_distance, o_last);
            end else begin
                want = dist_fifo.pop_front();
                if (o_center_number !== want.center_number || o_distance !== want.distance ||
                    o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: exp center %0d dist %0d last %0b, got %0d %0d %0b",
                                 want.center_number, want.distance, want.last,
                                 o_center_number, o_distance, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int items_left;
        int n;
        int c;
        logic act;

        // fill every slot with the origin so reset defaults can be read off directly
        dir_rows.push_back(item_row(ACT_QUERY, 0, 3, 4, 12, 1'b1, 5));
        dir_rows.push_back(cfg_row(REG_DIMENSION, 3));
        dir_rows.push_back(item_row(ACT_QUERY, 0, 3, 4, 12, 1'b1, 13));
        dir_rows.push_back(cfg_row(REG_DIMENSION, 0));
        dir_rows.push_back(item_row(ACT_QUERY, 5, -3, 4, 12, 1'b1, 3));
        dir_rows.push_back(cfg_row(REG_CENTERS, 1));
        dir_rows.push_back(item_row(ACT_LOAD, 0, -32768, -32768, -32768, 1'b0, 0));
        dir_rows.push_back(cfg_row(REG_DIMENSION, 3));
        dir_rows.push_back(item_row(ACT_QUERY, 63, 32767, 32767, 32767, 1'b1, 113509));
        dir_rows.push_back(cfg_row(REG_DIMENSION, 'h7E));
        dir_rows.push_back(item_row(ACT_QUERY, 0, 32767, 32767, 32767, 1'b1, 92680));
        dir_rows.push_back(cfg_row(REG_DIMENSION, 1));
        dir_rows.push_back(item_row(ACT_QUERY, 0, 32767, 32767, 32767, 1'b1, 65535));
        dir_rows.push_back(item_row(ACT_LOAD, 0, 32767, -32768, 0, 1'b0, 0));
        dir_rows.push_back(item_row(ACT_QUERY, 21, 32767, 0, 0, 1'b1, 0));
        dir_rows.push_back(cfg_row(REG_CENTERS, 0));
        dir_rows.push_back(item_row(ACT_QUERY, 0, 1, 2, 3, 1'b1, 0));
        dir_rows.push_back(cfg_row(REG_CENTERS, 127));
        dir_rows.push_back(cfg_row(REG_DIMENSION, 3));
        dir_rows.push_back(item_row(ACT_LOAD, 63, 12345, -12345, 1, 1'b0, 0));
        dir_rows.push_back(item_row(ACT_QUERY, 0, -32768, 32767, -1, 1'b0, 0));
        dir_rows.push_back(item_row(ACT_LOAD, 42, -1, 0, 32767, 1'b0, 0));
        dir_rows.push_back(cfg_row(REG_CENTERS, 64));
        dir_rows.push_back(item_row(ACT_QUERY, 0, 0, 0, 0, 1'b0, 0));
        dir_rows.push_back(item_row(ACT_QUERY, 63, 32767, -32768, -32768, 1'b0, 0));

        cfg_dim     = DIM_RESET;
        cfg_centers = CENT_RESET;
        for (int s = 0; s < N_CENTERS; s++)
            for (int k = 0; k < N_DIMS; k++)
                center_tab[s][k] = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int s = 0; s < N_CENTERS; s++)
            send_item(ACT_LOAD, SLOT_W'(s), '0, '0, '0, 1'b0, 0);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].reg_ix, dir_rows[i].reg_data);
            else
                send_item(dir_rows[i].action, dir_rows[i].slot, dir_rows[i].x,
                          dir_rows[i].y, dir_rows[i].z, dir_rows[i].typed,
                          dir_rows[i].typed_dist);
        end

        items_left = RANDOM_ITEMS;
        while (items_left > 0) begin
            write_reg(REG_DIMENSION, CFG_D_W'($urandom_range(0, 127)));
            case ($urandom_range(0, 19))
                0:       c = 0;
                1:       c = N_CENTERS;
                2:       c = $urandom_range(N_CENTERS + 1, 127);
                3, 4:    c = $urandom_range(9, N_CENTERS - 1);
                default: c = $urandom_range(1, 8);
            endcase
            write_reg(REG_CENTERS, CFG_D_W'(c));
            n = $urandom_range(20, 50);
            for (int j = 0; j < n && items_left > 0; j++) begin
                act = ($urandom_range(0, 99) < 35) ? ACT_QUERY : ACT_LOAD;
                send_item(act,
                          SLOT_W'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                       : $urandom_range(0, 63)),
                          rand_coord(), rand_coord(), rand_coord(), 1'b0, 0);
                items_left--;
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        while (dist_fifo.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/ped_pkg.sv
rtl/ped_ram.sv
rtl/ped_sqrt.sv
rtl/pairwise_euclidean_distance.sv
verif/tb_top.sv
